@@ src/stt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants for the timer slot table: sizes, input kinds and
// result status codes.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Table size and time width
    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Field widths of the stream beats
    localparam int KIND_W   = 3;
    localparam int TID_W    = 4;
    localparam int STATUS_W = 2;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_ONCE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET_REP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

endpackage

@@ src/stt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/software_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table
// Table of countdown timer slots. Set kinds allocate the lowest free slot,
// pause/resume/stop/query address one slot, a tick walks every slot and
// reports each one that fires, then closes with a beat flagged tlast.
//
//   channel  | direction | beat contents
//   ---------+-----------+----------------------------------------------------
//   s_*      | in        | tuser: kind; tdata: timer_id, duration_us, elapsed
//   m_*      | out       | tuser: fired; tdata: status, slot_id, is_paused,
//            |           | remaining_us; tlast: last
//
// One request at a time. Set, pause, resume, stop and query raise their
// result beat from S_EXEC once the output register is free, then return
// to S_IDLE for the next request. A tick walks the slots in S_TICK and
// raises its closing beat from S_TEND: the walk reads one slot a cycle
// from the time and reload RAMs, unless an output stall holds it, and
// writes the countdown back once the read word arrives. Output stalls hold
// the walk on a firing slot and hold any pending result beat. Reset clears
// the slot flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_table
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_id[3:0], duration_us[35:4], elapsed_us[67:36], 0
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], slot_id[5:2], is_paused[6],
                                   // remaining_us[38:7], 0
    output logic        m_tuser,   // fired
    output logic        m_tlast
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_TEND = 2'd3;

    logic [1:0]           state_reg, state_next;

    // Latched request
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [TID_W-1:0]     tid_reg, tid_next;
    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic [TIME_BITS-1:0] el_reg, el_next;

    // Per-slot flags
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] paused_reg, paused_next;
    logic [NUM_SLOTS-1:0] repeat_reg, repeat_next;

    // Tick walk
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 proc_vld_reg, proc_vld_next;
    logic [SLOT_W-1:0]    proc_idx_reg, proc_idx_next;

    // Output register
    logic                 out_vld_reg, out_vld_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [TID_W-1:0]     out_slot_reg, out_slot_next;
    logic                 out_fired_reg, out_fired_next;
    logic                 out_paused_reg, out_paused_next;
    logic [TIME_BITS-1:0] out_remain_reg, out_remain_next;
    logic                 out_last_reg, out_last_next;

    // RAM ports
    logic                 tm_we, rl_we, ram_re;
    logic [SLOT_W-1:0]    tm_wa, rl_wa, ram_ra;
    logic [TIME_BITS-1:0] tm_wd, rl_wd, tm_rd, rl_rd;

    // Helpers
    logic                 in_beat;
    logic                 out_free;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [SLOT_W-1:0]    tid_slot;
    logic                 tid_ok;
    logic                 p_run;
    logic [TIME_BITS-1:0] t_sub;
    logic                 p_fire;
    logic                 tick_stall;
    logic                 tick_issue;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Addressed slot check
    assign tid_slot = tid_reg[SLOT_W-1:0];
    assign tid_ok   = ({1'b0, tid_reg} < (TID_W + 1)'(NUM_SLOTS)) && valid_reg[tid_slot];

    // Countdown of the slot under processing
    assign p_run  = valid_reg[proc_idx_reg] && active_reg[proc_idx_reg]
                    && !paused_reg[proc_idx_reg];
    assign t_sub  = (tm_rd > el_reg) ? (tm_rd - el_reg) : '0;
    assign p_fire = proc_vld_reg && p_run && (t_sub == '0);

    assign tick_stall = p_fire && !out_free;
    assign tick_issue = (state_reg == S_TICK) && !tick_stall
                        && (rd_idx_reg < CNT_W'(NUM_SLOTS));

    // RAM read: request slot on accept, walk index during a tick
    assign ram_re = in_beat || tick_issue;
    assign ram_ra = (state_reg == S_IDLE) ? s_tdata[SLOT_W-1:0] : rd_idx_reg[SLOT_W-1:0];

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        tid_next        = tid_reg;
        dur_next        = dur_reg;
        el_next         = el_reg;
        valid_next      = valid_reg;
        active_next     = active_reg;
        paused_next     = paused_reg;
        repeat_next     = repeat_reg;
        rd_idx_next     = rd_idx_reg;
        proc_vld_next   = proc_vld_reg;
        proc_idx_next   = proc_idx_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_fired_next  = out_fired_reg;
        out_paused_next = out_paused_reg;
        out_remain_next = out_remain_reg;
        out_last_next   = out_last_reg;
        tm_we           = 1'b0;
        tm_wa           = proc_idx_reg;
        tm_wd           = t_sub;
        rl_we           = 1'b0;
        rl_wa           = free_idx;
        rl_wd           = dur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    tid_next   = s_tdata[3:0];
                    dur_next   = s_tdata[35:4];
                    el_next    = s_tdata[67:36];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (kind_reg == KIND_TICK)
                begin
                    rd_idx_next   = '0;
                    proc_vld_next = 1'b0;
                    state_next    = S_TICK;
                end
                else if (out_free)
                begin
                    // default single beat: all zero, last
                    out_vld_next    = 1'b1;
                    out_status_next = STAT_OK;
                    out_slot_next   = '0;
                    out_fired_next  = 1'b0;
                    out_paused_next = 1'b0;
                    out_remain_next = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    if (kind_reg == KIND_SET_ONCE || kind_reg == KIND_SET_REP)
                    begin
                        if (free_found)
                        begin
                            valid_next[free_idx]  = 1'b1;
                            active_next[free_idx] = 1'b1;
                            paused_next[free_idx] = 1'b0;
                            repeat_next[free_idx] = (kind_reg == KIND_SET_REP);
                            tm_we                 = 1'b1;
                            tm_wa                 = free_idx;
                            tm_wd                 = dur_reg;
                            rl_we                 = 1'b1;
                            rl_wd                 = (kind_reg == KIND_SET_REP) ? dur_reg : '0;
                            out_slot_next         = TID_W'(free_idx);
                        end
                        else
                        begin
                            out_status_next = STAT_FULL;
                        end
                    end
                    else if (kind_reg == KIND_PAUSE || kind_reg == KIND_RESUME
                             || kind_reg == KIND_STOP || kind_reg == KIND_QUERY)
                    begin
                        out_slot_next = tid_reg;
                        if (!tid_ok)
                        begin
                            out_status_next = STAT_UNUSED;
                        end
                        else
                        begin
                            case (kind_reg)
                                KIND_PAUSE:  paused_next[tid_slot] = 1'b1;
                                KIND_RESUME: paused_next[tid_slot] = 1'b0;
                                KIND_STOP:   active_next[tid_slot] = 1'b0;
                                default:
                                begin
                                    out_paused_next = paused_reg[tid_slot];
                                    out_remain_next = tm_rd;
                                end
                            endcase
                        end
                    end
                end
            end

            S_TICK:
            begin
                if (!tick_stall)
                begin
                    // process the slot whose time word arrived this cycle
                    if (proc_vld_reg && valid_reg[proc_idx_reg])
                    begin
                        if (!active_reg[proc_idx_reg])
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                        end
                        else if (!paused_reg[proc_idx_reg])
                        begin
                            tm_we = 1'b1;
                            if (p_fire)
                            begin
                                tm_wd = repeat_reg[proc_idx_reg] ? rl_rd : '0;
                                if (!repeat_reg[proc_idx_reg])
                                begin
                                    valid_next[proc_idx_reg] = 1'b0;
                                end
                                out_vld_next    = 1'b1;
                                out_status_next = STAT_OK;
                                out_slot_next   = TID_W'(proc_idx_reg);
                                out_fired_next  = 1'b1;
                                out_paused_next = 1'b0;
                                out_remain_next = repeat_reg[proc_idx_reg] ? rl_rd : '0;
                                out_last_next   = 1'b0;
                            end
                        end
                    end

                    // advance the walk
                    proc_vld_next = tick_issue;
                    proc_idx_next = rd_idx_reg[SLOT_W-1:0];
                    if (tick_issue)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (proc_vld_reg && proc_idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    begin
                        state_next = S_TEND;
                    end
                end
            end

            S_TEND:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = STAT_OK;
                    out_slot_next   = '0;
                    out_fired_next  = 1'b0;
                    out_paused_next = 1'b0;
                    out_remain_next = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            active_reg   <= '0;
            paused_reg   <= '0;
            repeat_reg   <= '0;
            rd_idx_reg   <= '0;
            proc_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            active_reg   <= active_next;
            paused_reg   <= paused_next;
            repeat_reg   <= repeat_next;
            rd_idx_reg   <= rd_idx_next;
            proc_vld_reg <= proc_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        tid_reg        <= tid_next;
        dur_reg        <= dur_next;
        el_reg         <= el_next;
        proc_idx_reg   <= proc_idx_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_fired_reg  <= out_fired_next;
        out_paused_reg <= out_paused_next;
        out_remain_reg <= out_remain_next;
        out_last_reg   <= out_last_next;
    end

    // Remaining time per slot
    stt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (tm_we),
        .wr_addr (tm_wa),
        .wr_data (tm_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (tm_rd)
    );

    // Reload interval per slot
    stt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_reload_ram (
        .clk     (clk),
        .wr_en   (rl_we),
        .wr_addr (rl_wa),
        .wr_data (rl_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (rl_rd)
    );

    // Output beat
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_remain_reg, out_paused_reg, out_slot_reg, out_status_reg};
    assign m_tuser  = out_fired_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/stt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// Watches both stream channels of the timer slot table. Every request beat
// is run through a local copy of the slot table to work out the result
// beats it owes; each result beat is then compared field by field with the
// oldest one still owed. Reports the mismatch count and the number of
// result beats still owed.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,     // timer_id[3:0], duration_us[35:4], elapsed_us[67:36], 0
    input  logic [2:0]  s_tuser,     // kind[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,     // status[1:0], slot_id[5:2], is_paused[6],
                                     // remaining_us[38:7], 0
    input  logic        m_tuser,     // fired
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    // One result beat, unpacked
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_id;
        logic                fired;
        logic                is_paused;
        logic [31:0]         remaining_us;
        logic                last;
    } timer_report_t;

    // Local copy of the slot table
    bit                   slot_used     [NUM_SLOTS];
    bit                   slot_running  [NUM_SLOTS];
    bit                   slot_held     [NUM_SLOTS];
    bit                   slot_periodic [NUM_SLOTS];
    logic [TIME_BITS-1:0] countdown     [NUM_SLOTS];
    logic [TIME_BITS-1:0] period        [NUM_SLOTS];

    // Result beats owed by the block, oldest first
    timer_report_t owed_reports[$];

    function automatic void owe(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                logic fired, logic held, logic [31:0] remain, logic last);
        timer_report_t r;
        r.status       = status;
        r.slot_id      = slot;
        r.fired        = fired;
        r.is_paused    = held;
        r.remaining_us = remain;
        r.last         = last;
        owed_reports   = {owed_reports, r};
    endfunction

    // Apply one request to the table and queue the results it causes
    function automatic void update_slot_table(logic [KIND_W-1:0] kind, logic [TID_W-1:0] tid,
                                              logic [31:0] dur, logic [31:0] el);
        int  i;
        bit  placed;
        placed = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!slot_used[i])
                        continue;
                    // stopped slot: freed silently
                    if (!slot_running[i])
                    begin
                        slot_used[i] = 1'b0;
                        continue;
                    end
                    if (slot_held[i])
                        continue;
                    countdown[i] = (countdown[i] > el) ? countdown[i] - el : '0;
                    if (countdown[i] == '0)
                    begin
                        // interval reloads in full, overshoot dropped
                        if (slot_periodic[i])
                            countdown[i] = period[i];
                        else
                            slot_used[i] = 1'b0;
                        owe(STAT_OK, SLOT_W'(i), 1'b1, 1'b0, 32'(countdown[i]), 1'b0);
                    end
                end
                owe(STAT_OK, '0, 1'b0, 1'b0, '0, 1'b1);
            end
            KIND_SET_ONCE, KIND_SET_REP:
            begin
                for (i = 0; i < NUM_SLOTS && !placed; i++)
                begin
                    if (!slot_used[i])
                    begin
                        placed           = 1'b1;
                        slot_used[i]     = 1'b1;
                        slot_running[i]  = 1'b1;
                        slot_held[i]     = 1'b0;
                        slot_periodic[i] = (kind == KIND_SET_REP);
                        countdown[i]     = dur;
                        period[i]        = (kind == KIND_SET_REP) ? dur : '0;
                        owe(STAT_OK, SLOT_W'(i), 1'b0, 1'b0, '0, 1'b1);
                    end
                end
                if (!placed)
                    owe(STAT_FULL, '0, 1'b0, 1'b0, '0, 1'b1);
            end
            KIND_PAUSE, KIND_RESUME, KIND_STOP, KIND_QUERY:
            begin
                if (int'(tid) >= NUM_SLOTS || !slot_used[tid])
                    owe(STAT_UNUSED, SLOT_W'(tid), 1'b0, 1'b0, '0, 1'b1);
                else if (kind == KIND_QUERY)
                    owe(STAT_OK, SLOT_W'(tid), 1'b0, slot_held[tid], 32'(countdown[tid]), 1'b1);
                else
                begin
                    if (kind == KIND_PAUSE)
                        slot_held[tid] = 1'b1;
                    else if (kind == KIND_RESUME)
                        slot_held[tid] = 1'b0;
                    else
                        slot_running[tid] = 1'b0;
                    owe(STAT_OK, SLOT_W'(tid), 1'b0, 1'b0, '0, 1'b1);
                end
            end
            // undefined kind: a lone closing beat
            default:
                owe(STAT_OK, '0, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels at the edge; requests before results
    always @(posedge clk)
    begin : watch
        timer_report_t want;
        timer_report_t got;
        if (!rst_n)
        begin
            slot_used     = '{default: 1'b0};
            slot_running  = '{default: 1'b0};
            slot_held     = '{default: 1'b0};
            slot_periodic = '{default: 1'b0};
            owed_reports.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                update_slot_table(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[67:36]);
            if (m_tvalid && m_tready)
            begin
                got.status       = m_tdata[1:0];
                got.slot_id      = m_tdata[5:2];
                got.is_paused    = m_tdata[6];
                got.remaining_us = m_tdata[38:7];
                got.fired        = m_tuser;
                got.last         = m_tlast;
                if (owed_reports.size() == 0)
                begin
                    $display("%0t: result beat with none owed, expected nothing, actual %0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = owed_reports.pop_front();
                    flag_field("status", 32'(want.status), 32'(got.status));
                    flag_field("slot_id", 32'(want.slot_id), 32'(got.slot_id));
                    flag_field("fired", 32'(want.fired), 32'(got.fired));
                    flag_field("is_paused", 32'(want.is_paused), 32'(got.is_paused));
                    flag_field("remaining_us", want.remaining_us, got.remaining_us);
                    flag_field("last", 32'(want.last), 32'(got.last));
                end
            end
            outstanding = owed_reports.size();
        end
    end

endmodule

@@ tb/software_timer_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table_tb
// Drives requests into the timer slot table: a short directed walk through
// empty, stopped, paused, zero-length and saturating cases, then random
// episodes of allocation bursts, tick bursts, per-slot operations and mixed
// traffic, with random stalls on both channels. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module software_timer_table_tb
    import stt_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_UNDEF = 3'd7;
    localparam int TOTAL_ITEMS = 450;
    localparam int QUIET_FROM  = 390;    // no idling from here on
    localparam int IDLE_LIMIT  = 2000;   // cycles without any beat

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;          // timer_id[3:0], duration_us[35:4], elapsed_us[67:36], 0
    logic [2:0]  s_tuser  = '0;          // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;                // status[1:0], slot_id[5:2], is_paused[6],
                                         // remaining_us[38:7], 0
    logic        m_tuser;                // fired
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit idle_on     = 1'b1;

    software_timer_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stt_checker u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stall bursts while idling is on
    initial
    begin : sink_stall
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: too long with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Mostly short times so that slots fire, sometimes the extremes
    function automatic logic [31:0] pick_micros();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            4:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 60);
        endcase
    endfunction

    // Allocation fills from slot 0, so low ids are mostly in use
    function automatic logic [3:0] pick_slot();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, 7));
    endfunction

    function automatic logic [2:0] pick_kind(bit slot_ops_only);
        int r;
        r = slot_ops_only ? $urandom_range(55, 96) : $urandom_range(0, 99);
        if (r < 22) return KIND_TICK;
        if (r < 40) return KIND_SET_ONCE;
        if (r < 55) return KIND_SET_REP;
        if (r < 63) return KIND_PAUSE;
        if (r < 71) return KIND_RESUME;
        if (r < 79) return KIND_STOP;
        if (r < 97) return KIND_QUERY;
        return KIND_UNDEF;
    endfunction

    // One request beat; returns at the edge where it was taken
    task automatic push_request(logic [2:0] kind, logic [3:0] tid, logic [31:0] dur,
                                logic [31:0] el);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, el, dur, tid};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind != KIND_UNDEF)
            items_sent++;
    endtask

    // Hold off until every owed result beat has come back
    task automatic let_table_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every slot op misses, tick only closes
        push_request(KIND_QUERY, 4'd0, '0, '0);
        push_request(KIND_PAUSE, 4'd15, '0, '0);
        push_request(KIND_RESUME, 4'd15, '0, '0);
        push_request(KIND_STOP, 4'd15, '0, '0);
        push_request(KIND_TICK, 4'd0, '0, '0);
        push_request(KIND_UNDEF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero-length timeout and interval, longest timeout, short interval
        push_request(KIND_SET_ONCE, 4'd0, '0, '0);
        push_request(KIND_SET_REP, 4'd0, '0, '0);
        push_request(KIND_SET_ONCE, 4'd0, 32'hFFFF_FFFF, '0);
        push_request(KIND_SET_REP, 4'd0, 32'd5, '0);
        push_request(KIND_QUERY, 4'd2, '0, '0);
        push_request(KIND_PAUSE, 4'd3, '0, '0);
        push_request(KIND_QUERY, 4'd3, '0, '0);
        // zero elapsed still fires zero-length slots, paused one skipped
        push_request(KIND_TICK, 4'd0, '0, '0);
        push_request(KIND_RESUME, 4'd3, '0, '0);
        // stopped slot stays in use and is not handed out again
        push_request(KIND_STOP, 4'd2, '0, '0);
        push_request(KIND_QUERY, 4'd2, '0, '0);
        push_request(KIND_SET_ONCE, 4'd0, 32'd7, '0);
        push_request(KIND_SET_REP, 4'd0, 32'd9, '0);
        // huge elapsed: everything running fires, overshoot dropped on reload
        push_request(KIND_TICK, 4'd0, '0, 32'hFFFF_FFFF);
        push_request(KIND_QUERY, 4'd2, '0, '0);
        push_request(KIND_TICK, 4'd0, '0, 32'd3);
        push_request(KIND_QUERY, 4'd3, '0, '0);
        push_request(KIND_QUERY, 4'd4, '0, '0);
        let_table_settle();

        // random episodes
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= QUIET_FROM)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                // allocation burst, often runs the table full
                0:
                    repeat ($urandom_range(10, 18))
                        push_request($urandom_range(0, 1) ? KIND_SET_REP : KIND_SET_ONCE,
                                     pick_slot(), pick_micros(), pick_micros());
                // tick burst
                1:
                    repeat ($urandom_range(3, 10))
                        push_request(KIND_TICK, pick_slot(), pick_micros(), pick_micros());
                // per-slot operations
                2:
                    repeat ($urandom_range(6, 16))
                        push_request(pick_kind(1'b1), pick_slot(), pick_micros(), pick_micros());
                default:
                    repeat ($urandom_range(5, 20))
                        push_request(pick_kind(1'b0), pick_slot(), pick_micros(), pick_micros());
            endcase
            if ($urandom_range(0, 4) == 0)
                let_table_settle();
        end

        let_table_settle();
        repeat (NUM_SLOTS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/stt_pkg.sv
src/stt_ram.sv
src/software_timer_table.sv
tb/stt_checker.sv
tb/software_timer_table_tb.sv
